// ===== rtl/csmac_pkg.sv =====
// Shared types, codes and BCD helpers for the clock set menu and alarm controller.
package csmac_pkg;

   // Tick count at which the blink phase flips
   localparam logic [5:0] TICKS_PER_BLINK = 6'd40;

   // BCD limits and digit handling
   localparam logic [6:0] MINUTE_LAST = 7'h59;
   localparam logic [6:0] HOUR_WRAP   = 7'h24;
   localparam logic [3:0] DIGIT_TEN   = 4'ha;
   localparam logic [6:0] TENS_STEP   = 7'h10;

   // Event codes
   localparam logic [2:0] CMD_SET        = 3'd0;
   localparam logic [2:0] CMD_PLUS       = 3'd1;
   localparam logic [2:0] CMD_LOAD_TIME  = 3'd2;
   localparam logic [2:0] CMD_TICK       = 3'd3;
   localparam logic [2:0] CMD_LOAD_ALARM = 3'd4;

   // Menu pages
   localparam logic [2:0] MENU_NORMAL    = 3'd0;
   localparam logic [2:0] MENU_MINUTE    = 3'd1;
   localparam logic [2:0] MENU_HOUR      = 3'd2;
   localparam logic [2:0] MENU_AL_MINUTE = 3'd3;
   localparam logic [2:0] MENU_AL_HOUR   = 3'd4;
   localparam logic [2:0] MENU_BRIGHT    = 3'd5;
   localparam logic [2:0] MENU_AL_ENABLE = 3'd6;
   localparam logic [2:0] MENU_TEMP      = 3'd7;
   localparam logic [2:0] MENU_LAST      = 3'd7;

   // Request codes
   localparam logic [1:0] REQ_NONE         = 2'd0;
   localparam logic [1:0] REQ_RELOAD_ALARM = 2'd1;
   localparam logic [1:0] REQ_WRITE_TIME   = 2'd2;
   localparam logic [1:0] REQ_SECS_CLEARED = 2'd3;

   typedef struct packed {
      logic [2:0] command;
      logic [5:0] load_hour;
      logic [6:0] load_minute;
   } csmac_req_type;

   typedef struct packed {
      logic [2:0] menu_index;
      logic [5:0] hour_bcd;
      logic [6:0] minute_bcd;
      logic [5:0] alarm_hour_bcd;
      logic [6:0] alarm_minute_bcd;
      logic       auto_bright;
      logic       alarm_enabled;
      logic       alarm_silenced;
      logic       temp_view;
      logic       bell_on;
      logic       blink_phase;
      logic [1:0] request;
   } csmac_rsp_type;

   // Controller state carried between events
   typedef struct packed {
      logic [2:0] menu;
      logic [5:0] hour;
      logic [6:0] minute;
      logic [5:0] alarm_hour;
      logic [6:0] alarm_minute;
      logic       auto_bright;
      logic       alarm_enable;
      logic       silence;
      logic       temp_view;
      logic       bell_pin;
      logic       blink;
      logic [5:0] tick_count;
   } csmac_state_type;

   // State after reset: silence, bell pin (bell off) and blink up at one
   localparam csmac_state_type STATE_RESET = '{
      menu:         MENU_NORMAL,
      hour:         6'h00,
      minute:       7'h00,
      alarm_hour:   6'h00,
      alarm_minute: 7'h00,
      auto_bright:  1'b0,
      alarm_enable: 1'b0,
      silence:      1'b1,
      temp_view:    1'b0,
      bell_pin:     1'b1,
      blink:        1'b1,
      tick_count:   6'd0
   };

   // Carry a low digit of ten or more into the tens digit
   function automatic logic [6:0] bcd_fix(input logic [6:0] v);
      logic [6:0] r;
      if (v[3:0] >= DIGIT_TEN) begin
         r = {v[6:4], 4'h0} + TENS_STEP;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Minute step: wraps after 59 (or anything above)
   function automatic logic [6:0] inc_minute(input logic [6:0] v);
      logic [6:0] t;
      if (v >= MINUTE_LAST) begin
         t = 7'd0;
      end else begin
         t = v + 7'd1;
      end
      return bcd_fix(t);
   endfunction

   // Hour step: wraps at 24
   function automatic logic [5:0] inc_hour(input logic [5:0] v);
      logic [6:0] t;
      t = bcd_fix({1'b0, v} + 7'd1);
      if (t >= HOUR_WRAP) begin
         t = 7'd0;
      end
      return t[5:0];
   endfunction

endpackage

// ===== rtl/csmac_next.sv =====
// Next-state and result logic for one controller event.
module csmac_next
   import csmac_pkg::*;
(
   input  csmac_state_type cur,
   input  csmac_req_type   item,
   output csmac_state_type nxt,
   output csmac_rsp_type   rsp
);

   logic       match;
   logic [1:0] req_code;
   logic [2:0] menu_inc;
   logic [5:0] tick_inc;

   assign match    = (cur.hour == cur.alarm_hour) && (cur.minute == cur.alarm_minute);
   assign menu_inc = cur.menu + 3'd1;
   assign tick_inc = cur.tick_count + 6'd1;

   // Event decode
   always_comb begin
      nxt      = cur;
      req_code = REQ_NONE;
      case (item.command)
         CMD_SET: begin
            nxt.bell_pin = 1'b1;
            nxt.menu     = menu_inc;
            if (menu_inc == MENU_AL_MINUTE) begin
               req_code = REQ_RELOAD_ALARM;
            end
            if (cur.menu == MENU_LAST) begin
               req_code = REQ_WRITE_TIME;
            end
         end
         CMD_PLUS: begin
            case (cur.menu)
               MENU_NORMAL: begin
                  if (match) begin
                     nxt.silence = 1'b1;
                  end
               end
               MENU_MINUTE: begin
                  nxt.minute   = inc_minute(cur.minute);
                  nxt.bell_pin = 1'b1;
                  req_code     = REQ_SECS_CLEARED;
               end
               MENU_HOUR: begin
                  nxt.hour     = inc_hour(cur.hour);
                  nxt.bell_pin = 1'b1;
                  req_code     = REQ_SECS_CLEARED;
               end
               MENU_AL_MINUTE: begin
                  nxt.alarm_minute = inc_minute(cur.alarm_minute);
                  nxt.bell_pin     = 1'b1;
               end
               MENU_AL_HOUR: begin
                  nxt.alarm_hour = inc_hour(cur.alarm_hour);
                  nxt.bell_pin   = 1'b1;
               end
               MENU_BRIGHT:    nxt.auto_bright  = ~cur.auto_bright;
               MENU_AL_ENABLE: nxt.alarm_enable = ~cur.alarm_enable;
               MENU_TEMP:      nxt.temp_view    = ~cur.temp_view;
               default: ;
            endcase
         end
         CMD_LOAD_TIME: begin
            nxt.hour   = item.load_hour;
            nxt.minute = item.load_minute;
         end
         CMD_TICK: begin
            nxt.tick_count = tick_inc;
            if (tick_inc >= TICKS_PER_BLINK) begin
               nxt.tick_count = 6'd0;
               nxt.blink      = ~cur.blink;
               if (!cur.silence && match) begin
                  nxt.bell_pin = ~cur.bell_pin;
               end else begin
                  nxt.bell_pin = 1'b1;
               end
            end
         end
         CMD_LOAD_ALARM: begin
            nxt.alarm_hour   = item.load_hour;
            nxt.alarm_minute = item.load_minute;
         end
         default: ;
      endcase
      // The alarm-enable page keeps silence tied to the enable flag
      if (nxt.menu == MENU_AL_ENABLE) begin
         nxt.silence = ~nxt.alarm_enable;
      end
   end

   // Result reports the state after the event
   always_comb begin
      rsp.menu_index       = nxt.menu;
      rsp.hour_bcd         = nxt.hour;
      rsp.minute_bcd       = nxt.minute;
      rsp.alarm_hour_bcd   = nxt.alarm_hour;
      rsp.alarm_minute_bcd = nxt.alarm_minute;
      rsp.auto_bright      = nxt.auto_bright;
      rsp.alarm_enabled    = nxt.alarm_enable;
      rsp.alarm_silenced   = nxt.silence;
      rsp.temp_view        = nxt.temp_view;
      rsp.bell_on          = ~nxt.bell_pin;
      rsp.blink_phase      = nxt.blink;
      rsp.request          = req_code;
   end

endmodule

// ===== rtl/clock_set_menu_alarm_controller.sv =====
// An event passes from the input register through one combinational update
// step into the result register and the state registers; one event per cycle
// is taken while the result register is not held by rsp_stall.
// Input stage stalls only while it is full and the result register is held.
// Reset (synchronous, active high) clears menu, time, alarm and flags;
// silence, bell pin (bell off) and blink phase come up at one.
module clock_set_menu_alarm_controller
   import csmac_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  csmac_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output csmac_rsp_type rsp_data
);

   logic            in_valid_ff;
   csmac_req_type   in_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   csmac_rsp_type   out_data_ff;
   csmac_state_type state_ff;
   csmac_state_type state_in;
   csmac_rsp_type   rsp_in;
   logic            out_free;
   logic            step;

   // Handshake between input register and result register
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign step         = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   csmac_next u_next (
      .cur  (state_ff),
      .item (in_data_ff),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Tick counter never reaches the blink period
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.tick_count < TICKS_PER_BLINK)
      else $error("tick count out of range");

   // A processed event leaves the result menu equal to the state menu
   a_menu_track: assert property (@(posedge clock) disable iff (reset)
      step |=> (out_data_ff.menu_index == state_ff.menu))
      else $error("result menu differs from state");

   // On the alarm-enable page silence is the inverse of enable
   a_menu_six: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.menu_index == MENU_AL_ENABLE)
      |-> (out_data_ff.alarm_silenced != out_data_ff.alarm_enabled))
      else $error("menu six silence rule broken");

   // A time write request only comes with the menu back at normal
   a_write_menu: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.request == REQ_WRITE_TIME)
      |-> (out_data_ff.menu_index == MENU_NORMAL))
      else $error("write request outside normal menu");

   // A waiting input item is always stalled while the result is held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> in_valid_ff)
      else $error("input item lost while stalled");

endmodule

// ===== tb/sv/clock_set_menu_alarm_controller_tb.sv =====
// Self-checking testbench for the clock set menu and alarm controller.
`timescale 1ns / 1ps

module clock_set_menu_alarm_controller_tb
   import csmac_pkg::*;
;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned IDLE_PCT    = 9;
   localparam int unsigned HOLD_AT     = 400;   // events sent before the long rsp hold-off
   localparam int unsigned HOLD_LEN    = 300;
   localparam int unsigned BUSY_FROM   = 1100;  // window with no idling on either side
   localparam int unsigned BUSY_TO     = 1400;
   localparam int unsigned TAIL_CYCLES = 8;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   csmac_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   csmac_rsp_type rsp_data;

   clock_set_menu_alarm_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   csmac_req_type pending_events[$];
   csmac_rsp_type expected_displays[$];

   int unsigned stim_total      = 0;
   int unsigned events_sent     = 0;
   int unsigned results_checked = 0;
   int unsigned error_count     = 0;
   int unsigned cycle_count     = 0;
   int unsigned ticks_applied   = 0;
   int unsigned blink_flips     = 0;
   int unsigned bell_results    = 0;
   int unsigned requests_raised = 0;

   logic [2:0]  gen_menu = MENU_NORMAL;  // menu as tracked by the stimulus generator
   logic        offer_taken = 1'b0;
   logic        hold_done = 1'b0;
   int unsigned hold_left = 0;

   // Predicted controller state, reset values
   logic [2:0] menu_now        = MENU_NORMAL;
   logic [7:0] hour_now        = 8'h00;
   logic [7:0] minute_now      = 8'h00;
   logic [7:0] al_hour_now     = 8'h00;
   logic [7:0] al_minute_now   = 8'h00;
   logic       bright_now      = 1'b0;
   logic       alarm_en_now    = 1'b0;
   logic       silence_now     = 1'b1;
   logic       temp_now        = 1'b0;
   logic       bell_pin_now    = 1'b1;
   logic       blink_now       = 1'b1;
   logic [5:0] ticks_now       = 6'd0;

   // BCD helpers, kept 8 bits wide so out-of-range loads behave as on the target
   function automatic logic [7:0] bcd_carry(logic [7:0] v);
      if (v[3:0] >= DIGIT_TEN) begin
         return {v[7:4], 4'h0} + 8'h10;
      end
      return v;
   endfunction

   function automatic logic [7:0] next_minute(logic [7:0] v);
      return bcd_carry((v >= MINUTE_LAST) ? 8'h00 : v + 8'h01);
   endfunction

   function automatic logic [7:0] next_hour(logic [7:0] v);
      logic [7:0] t;
      t = bcd_carry(v + 8'h01);
      return (t >= HOUR_WRAP) ? 8'h00 : t;
   endfunction

   // Advance the predicted state by one event and return the display it should show
   function automatic csmac_rsp_type apply_event(csmac_req_type ev);
      csmac_rsp_type r;
      logic [1:0]    req;
      logic          alarm_hit;
      req = REQ_NONE;
      alarm_hit = (hour_now == al_hour_now) && (minute_now == al_minute_now);
      case (ev.command)
         CMD_SET: begin
            bell_pin_now = 1'b1;
            if (menu_now == MENU_LAST) begin
               menu_now = MENU_NORMAL;
               req = REQ_WRITE_TIME;
            end else begin
               menu_now = menu_now + 3'd1;
               if (menu_now == MENU_AL_MINUTE) req = REQ_RELOAD_ALARM;
            end
         end
         CMD_PLUS: begin
            case (menu_now)
               MENU_NORMAL: begin
                  if (alarm_hit) silence_now = 1'b1;
               end
               MENU_MINUTE: begin
                  minute_now = next_minute(minute_now);
                  bell_pin_now = 1'b1;
                  req = REQ_SECS_CLEARED;
               end
               MENU_HOUR: begin
                  hour_now = next_hour(hour_now);
                  bell_pin_now = 1'b1;
                  req = REQ_SECS_CLEARED;
               end
               MENU_AL_MINUTE: begin
                  al_minute_now = next_minute(al_minute_now);
                  bell_pin_now = 1'b1;
               end
               MENU_AL_HOUR: begin
                  al_hour_now = next_hour(al_hour_now);
                  bell_pin_now = 1'b1;
               end
               MENU_BRIGHT:    bright_now = !bright_now;
               MENU_AL_ENABLE: alarm_en_now = !alarm_en_now;
               default:        temp_now = !temp_now;
            endcase
         end
         CMD_LOAD_TIME: begin
            hour_now = {2'b00, ev.load_hour};
            minute_now = {1'b0, ev.load_minute};
         end
         CMD_TICK: begin
            ticks_applied++;
            ticks_now = ticks_now + 6'd1;
            if (ticks_now >= TICKS_PER_BLINK) begin
               ticks_now = 6'd0;
               blink_now = !blink_now;
               blink_flips++;
               if (!silence_now && alarm_hit) begin
                  bell_pin_now = !bell_pin_now;
               end else begin
                  bell_pin_now = 1'b1;
               end
            end
         end
         CMD_LOAD_ALARM: begin
            al_hour_now = {2'b00, ev.load_hour};
            al_minute_now = {1'b0, ev.load_minute};
         end
         default: ;  // unused codes leave the state alone
      endcase
      // the enable page polls silence continuously
      if (menu_now == MENU_AL_ENABLE) silence_now = !alarm_en_now;

      r.menu_index       = menu_now;
      r.hour_bcd         = hour_now[5:0];
      r.minute_bcd       = minute_now[6:0];
      r.alarm_hour_bcd   = al_hour_now[5:0];
      r.alarm_minute_bcd = al_minute_now[6:0];
      r.auto_bright      = bright_now;
      r.alarm_enabled    = alarm_en_now;
      r.alarm_silenced   = silence_now;
      r.temp_view        = temp_now;
      r.bell_on          = !bell_pin_now;
      r.blink_phase      = blink_now;
      r.request          = req;
      if (r.bell_on) bell_results++;
      if (req != REQ_NONE) requests_raised++;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [6:0] got, logic [6:0] want);
      $display("mismatch at result %0d: %s got %0h want %0h", results_checked, what, got, want);
      error_count++;
   endtask

   task automatic compare_field(string name, logic [6:0] got, logic [6:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic check_display(csmac_rsp_type got, csmac_rsp_type want);
      compare_field("menu_index", 7'(got.menu_index), 7'(want.menu_index));
      compare_field("hour_bcd", 7'(got.hour_bcd), 7'(want.hour_bcd));
      compare_field("minute_bcd", got.minute_bcd, want.minute_bcd);
      compare_field("alarm_hour_bcd", 7'(got.alarm_hour_bcd), 7'(want.alarm_hour_bcd));
      compare_field("alarm_minute_bcd", got.alarm_minute_bcd, want.alarm_minute_bcd);
      compare_field("auto_bright", 7'(got.auto_bright), 7'(want.auto_bright));
      compare_field("alarm_enabled", 7'(got.alarm_enabled), 7'(want.alarm_enabled));
      compare_field("alarm_silenced", 7'(got.alarm_silenced), 7'(want.alarm_silenced));
      compare_field("temp_view", 7'(got.temp_view), 7'(want.temp_view));
      compare_field("bell_on", 7'(got.bell_on), 7'(want.bell_on));
      compare_field("blink_phase", 7'(got.blink_phase), 7'(want.blink_phase));
      compare_field("request", 7'(got.request), 7'(want.request));
   endtask

   // Input driver: record a transfer at the rising edge, offer the next event at the falling
   always begin
      @(posedge clock);
      offer_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         expected_displays.push_back(apply_event(req_data));
         events_sent++;
         offer_taken = 1'b1;
      end
      @(negedge clock);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || offer_taken) begin
         if (pending_events.size() != 0 &&
             ((events_sent >= BUSY_FROM && events_sent < BUSY_TO) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data <= pending_events.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: check transfers at the rising edge, drive stall at the falling
   always begin
      @(posedge clock);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_displays.size() == 0) begin
            report_mismatch("result with nothing pending, request", 7'(rsp_data.request),
                            7'h0);
         end else begin
            check_display(rsp_data, expected_displays.pop_front());
         end
         results_checked++;
      end
      @(negedge clock);
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && events_sent >= HOLD_AT) begin
         // long hold-off so the controller fills and backs up its input
         hold_done = 1'b1;
         hold_left = HOLD_LEN - 1;
         rsp_stall <= 1'b1;
      end else if (reset || (results_checked >= BUSY_FROM && results_checked < BUSY_TO)) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_displays.size());
         $display("[clock_set_menu_alarm_controller] ERROR");
         $finish;
      end
   end

   // Queue one event; the generator tracks the menu so sequences can steer it
   task automatic post_event(logic [2:0] cmd, logic [5:0] hr, logic [6:0] mn);
      csmac_req_type ev;
      ev.command = cmd;
      ev.load_hour = hr;
      ev.load_minute = mn;
      pending_events.push_back(ev);
      stim_total++;
      if (cmd == CMD_SET) begin
         gen_menu = (gen_menu == MENU_LAST) ? MENU_NORMAL : gen_menu + 3'd1;
      end
   endtask

   // Mostly legal BCD, now and then any bit pattern
   function automatic logic [5:0] pick_hour();
      logic [1:0] tens;
      if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      tens = 2'($urandom_range(0, 2));
      return {tens, 4'($urandom_range(0, (tens == 2'd2) ? 3 : 9))};
   endfunction

   function automatic logic [6:0] pick_minute();
      if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
      return {3'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
   endfunction

   task automatic post_button(logic [2:0] cmd);
      post_event(cmd, 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)));
   endtask

   task automatic goto_menu(logic [2:0] target);
      while (gen_menu != target) post_button(CMD_SET);
   endtask

   // Random sequences: alarm ring-up, page edits, and raw noise
   task automatic queue_random_events(int unsigned target);
      logic [5:0]  hr;
      logic [6:0]  mn;
      int unsigned pick;
      while (stim_total < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            hr = pick_hour();
            mn = pick_minute();
            post_event(CMD_LOAD_TIME, hr, mn);
            post_event(CMD_LOAD_ALARM, hr, ($urandom_range(0, 4) == 0) ? pick_minute() : mn);
            goto_menu(MENU_AL_ENABLE);
            repeat ($urandom_range(0, 2)) post_button(CMD_PLUS);
            goto_menu(MENU_NORMAL);
            repeat ($urandom_range(30, 100)) begin
               pick = $urandom_range(0, 99);
               if (pick < 88) post_button(CMD_TICK);
               else if (pick < 93) post_button(CMD_PLUS);
               else if (pick < 96) post_button(CMD_SET);
               else post_event(3'($urandom_range(0, 7)), pick_hour(), pick_minute());
            end
         end else if (pick < 70) begin
            goto_menu(3'($urandom_range(1, 7)));
            repeat ($urandom_range(1, 30)) begin
               post_button(($urandom_range(0, 99) < 80) ? CMD_PLUS : CMD_TICK);
            end
         end else begin
            repeat ($urandom_range(4, 16)) begin
               post_event(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                          7'($urandom_range(0, 127)));
            end
         end
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (events_sent != stim_total || expected_displays.size() != 0);
   endtask

   initial begin
      // directed: every page, out-of-range loads, unused codes
      post_button(CMD_PLUS);                      // menu 0, time equals alarm at reset
      post_event(CMD_LOAD_TIME, 6'h3f, 7'h7f);
      post_event(CMD_LOAD_ALARM, 6'h3f, 7'h7f);
      post_button(CMD_SET);
      post_button(CMD_PLUS);                      // minute 7f wraps to 00
      post_button(CMD_SET);
      post_button(CMD_PLUS);                      // hour 3f carries past 24, wraps
      post_button(CMD_SET);                       // entering menu 3 reloads the alarm
      post_button(CMD_PLUS);
      post_button(CMD_SET);
      post_button(CMD_PLUS);
      post_button(CMD_SET);
      post_button(CMD_PLUS);                      // auto brightness
      post_button(CMD_SET);                       // enable page forces silence
      post_button(CMD_PLUS);                      // enable on, silence drops
      post_button(CMD_SET);
      post_button(CMD_PLUS);                      // temperature view
      post_button(CMD_SET);                       // wrap writes the time
      post_event(3'd5, 6'h3f, 7'h7f);
      post_event(3'd6, 6'h00, 7'h00);
      post_event(3'd7, 6'h2a, 7'h55);
      post_event(CMD_LOAD_TIME, 6'h23, 7'h59);
      post_button(CMD_PLUS);                      // menu 0 with no alarm match
      post_event(CMD_LOAD_ALARM, 6'h00, 7'h00);
      queue_random_events(875);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender waits here until every result of the first half is back
      wait_drained();
      @(posedge clock);
      queue_random_events(1750);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d events in %0d cycles: %0d ticks, %0d blink flips", events_sent,
               cycle_count, ticks_applied, blink_flips);
      $display("checked %0d results, %0d with the bell ringing, %0d carrying a request",
               results_checked, bell_results, requests_raised);
      if (error_count == 0) begin
         $display("[clock_set_menu_alarm_controller] OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[clock_set_menu_alarm_controller] ERROR");
      end
      $finish;
   end

endmodule
